>>> sv/stda_pkg.sv
// ----------------------------------------------------------------------------
// stda_pkg
// Shared types and constants of the strip to diffraction angle converter.
// ----------------------------------------------------------------------------
package stda_pkg;

  // The vector that one CORDIC iteration works on.
  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [31:0] z;
  } cordic_t;

  // Values that ride along the CORDIC stages unchanged.
  typedef struct packed {
    logic signed [45:0] cterm;
    logic signed [31:0] offset;
    logic signed [31:0] det;
  } side_t;

  // 2^20 * 180 / pi, rounded.
  localparam logic [25:0] RadToDeg = 26'd60078979;

  // Initial CORDIC x, 2^44.
  localparam logic signed [63:0] CordicX0 = 64'sh0000_1000_0000_0000;

  // atan(2^-i) in units of 2^-30 rad, truncated.
  function automatic logic signed [31:0] atan_const(input int unsigned i);
    logic signed [31:0] t;
    case (i)
      0:  t = 32'sh3243F6A8;
      1:  t = 32'sh1DAC6705;
      2:  t = 32'sh0FADBAFC;
      3:  t = 32'sh07F56EA6;
      4:  t = 32'sh03FEAB76;
      5:  t = 32'sh01FFD55B;
      6:  t = 32'sh00FFFAAA;
      7:  t = 32'sh007FFF55;
      8:  t = 32'sh003FFFEA;
      9:  t = 32'sh001FFFFD;
      10: t = 32'sh000FFFFF;
      11: t = 32'sh0007FFFF;
      12: t = 32'sh0003FFFF;
      13: t = 32'sh0001FFFF;
      14: t = 32'sh0000FFFF;
      15: t = 32'sh00007FFF;
      16: t = 32'sh00003FFF;
      17: t = 32'sh00001FFF;
      18: t = 32'sh00000FFF;
      19: t = 32'sh000007FF;
      20: t = 32'sh000003FF;
      21: t = 32'sh000001FF;
      22: t = 32'sh000000FF;
      23: t = 32'sh0000007F;
      24: t = 32'sh0000003F;
      25: t = 32'sh0000001F;
      26: t = 32'sh0000000F;
      27: t = 32'sh00000008;
      28: t = 32'sh00000004;
      29: t = 32'sh00000002;
      30: t = 32'sh00000001;
      default: t = 32'sh00000000;
    endcase
    return t;
  endfunction

endpackage

>>> sv/stda_ram.sv
// ----------------------------------------------------------------------------
// stda_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module stda_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/stda_cordic_step.sv
// ----------------------------------------------------------------------------
// stda_cordic_step
// One registered iteration of the vectoring CORDIC that computes atan.
// ----------------------------------------------------------------------------
module stda_cordic_step #(
  parameter int SHIFT = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             src_valid,
  input  stda_pkg::cordic_t src_vec,
  input  stda_pkg::side_t   src_side,
  output logic             dst_valid,
  output stda_pkg::cordic_t dst_vec,
  output stda_pkg::side_t   dst_side
);

  logic signed [63:0] dx;
  logic signed [63:0] dy;
  logic signed [31:0] t;
  stda_pkg::cordic_t  vec_next;

  assign dx = $signed(src_vec.y) >>> SHIFT;
  assign dy = $signed(src_vec.x) >>> SHIFT;
  assign t  = stda_pkg::atan_const(SHIFT);

  // Rotate toward the x axis: the sign of y picks the direction.
  always_comb begin
    if (!src_vec.y[63]) begin
      vec_next.x = src_vec.x + dx;
      vec_next.y = src_vec.y - dy;
      vec_next.z = src_vec.z + t;
    end else begin
      vec_next.x = src_vec.x - dx;
      vec_next.y = src_vec.y + dy;
      vec_next.z = src_vec.z - t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (advance) begin
      dst_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dst_vec  <= vec_next;
      dst_side <= src_side;
    end
  end

endmodule

>>> sv/strip_to_diffraction_angle.sv
// ----------------------------------------------------------------------------
// strip_to_diffraction_angle
// Converts a detector strip position to a diffraction angle using per-module
// calibration values held in an on-chip table.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while in_stall is low. A write item stores one
// module's offset, center and conversion and gives no result. A convert item
// passes through ATAN_STEPS + 8 register stages: one per CORDIC iteration plus
// eight for the table read, the strip mirror, the split multiplications, the
// CORDIC load, the clamp, the degree scaling, the rounding and the final
// saturating sum. The whole pipeline moves as one: while a result waits on
// out_stall, in_stall is high. A convert may follow a write to the same module
// in the next cycle.
module strip_to_diffraction_angle #(
  parameter int MODULES    = 64,
  parameter int STRIPS     = 1280,
  parameter int ATAN_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic [5:0]         module_id,
  input  logic [10:0]        strip_num,
  input  logic signed [9:0]  strip_fraction,
  input  logic signed [31:0] arm_angle,
  input  logic signed [31:0] new_offset,
  input  logic signed [31:0] new_center,
  input  logic signed [31:0] new_conversion,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] diffraction_angle,
  output logic               saturated
);

  localparam int AW = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam logic signed [46:0] ALimHi = 47'sh20_0000_0000;
  localparam logic signed [46:0] ALimLo = -ALimHi;
  localparam logic signed [37:0] SumMax = 38'sd2147483647;
  localparam logic signed [37:0] SumMin = -38'sd2147483648;

  logic advance;
  logic accept;
  logic hit;
  logic [AW-1:0] addr;
  logic [95:0] rd;

  assign in_stall = out_valid && out_stall;
  assign advance  = !in_stall;
  assign accept   = in_valid && !in_stall;
  assign hit      = 32'(module_id) < MODULES;
  assign addr     = AW'(module_id);

  stda_ram #(.WIDTH(96), .DEPTH(MODULES)) u_table (
    .clk  (clk),
    .we   (accept && opcode && hit),
    .waddr(addr),
    .wdata({new_offset, new_center, new_conversion}),
    .re   (advance),
    .raddr(addr),
    .rdata(rd)
  );

  // Stage 0: item fields, alongside the table read.
  logic               s0_valid;
  logic               s0_hit;
  logic [10:0]        s0_strip;
  logic signed [9:0]  s0_frac;
  logic signed [31:0] s0_det;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (advance) begin
      s0_valid <= in_valid && !opcode;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_hit   <= hit;
      s0_strip <= strip_num;
      s0_frac  <= strip_fraction;
      s0_det   <= arm_angle;
    end
  end

  // Stage 1: mirror the strip, take |conv| and form the distance to center.
  logic signed [31:0] c_off, c_cen, c_conv;
  logic signed [12:0] c_s;
  logic signed [29:0] c_p;

  assign c_off  = s0_hit ? $signed(rd[95:64]) : 32'sd0;
  assign c_cen  = s0_hit ? $signed(rd[63:32]) : 32'sd0;
  assign c_conv = s0_hit ? $signed(rd[31:0])  : 32'sd0;
  assign c_s    = c_conv[31] ? (13'(STRIPS - 1) - $signed(13'(s0_strip)))
                             : $signed(13'(s0_strip));
  assign c_p    = (30'(c_s) <<< 16) + (30'(s0_frac) <<< 8);

  logic               s1_valid;
  logic signed [31:0] s1_off, s1_cen, s1_det;
  logic [31:0]        s1_kabs;
  logic signed [33:0] s1_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_off  <= c_off;
      s1_cen  <= c_cen;
      s1_det  <= s0_det;
      s1_kabs <= c_conv[31] ? 32'(-c_conv) : 32'(c_conv);
      s1_d    <= 34'(c_cen) - 34'(c_p);
    end
  end

  // Stage 2: partial products on the two halves of |conv|.
  logic               s2_valid;
  logic signed [50:0] s2_pdl, s2_pdh;
  logic signed [48:0] s2_pcl, s2_pch;
  logic signed [31:0] s2_off, s2_det;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_pdl <= s1_d * $signed({1'b0, s1_kabs[15:0]});
      s2_pdh <= s1_d * $signed({1'b0, s1_kabs[31:16]});
      s2_pcl <= s1_cen * $signed({1'b0, s1_kabs[15:0]});
      s2_pch <= s1_cen * $signed({1'b0, s1_kabs[31:16]});
      s2_off <= s1_off;
      s2_det <= s1_det;
    end
  end

  // Stage 3: combine the products and load the CORDIC.
  logic signed [65:0] prod_d, prod_c;

  assign prod_d = (66'(s2_pdh) <<< 16) + 66'(s2_pdl);
  assign prod_c = (66'(s2_pch) <<< 16) + 66'(s2_pcl);

  logic              cv_valid [ATAN_STEPS+1];
  stda_pkg::cordic_t cv_vec   [ATAN_STEPS+1];
  stda_pkg::side_t   cv_side  [ATAN_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv_valid[0] <= 1'b0;
    end else if (advance) begin
      cv_valid[0] <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cv_vec[0].x        <= stda_pkg::CordicX0;
      cv_vec[0].y        <= 64'(prod_d >>> 4);
      cv_vec[0].z        <= 32'sd0;
      cv_side[0].cterm   <= 46'(prod_c >>> 18);
      cv_side[0].offset  <= s2_off;
      cv_side[0].det     <= s2_det;
    end
  end

  for (genvar i = 0; i < ATAN_STEPS; i++) begin : g_cordic
    stda_cordic_step #(.SHIFT(i)) u_step (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .src_valid(cv_valid[i]),
      .src_vec  (cv_vec[i]),
      .src_side (cv_side[i]),
      .dst_valid(cv_valid[i+1]),
      .dst_vec  (cv_vec[i+1]),
      .dst_side (cv_side[i+1])
    );
  end

  // Angle in radians, clamped; the clamp only bites where the sum saturates.
  stda_pkg::cordic_t  cl_vec;
  stda_pkg::side_t    cl_side;
  logic signed [46:0] a_full;

  assign cl_vec  = cv_vec[ATAN_STEPS];
  assign cl_side = cv_side[ATAN_STEPS];
  assign a_full  = 47'(cl_side.cterm) - 47'(cl_vec.z);

  logic               sa_valid;
  logic signed [38:0] sa_a;
  logic signed [31:0] sa_off, sa_det;

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid <= 1'b0;
    end else if (advance) begin
      sa_valid <= cv_valid[ATAN_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (a_full > ALimHi) begin
        sa_a <= 39'(ALimHi);
      end else if (a_full < ALimLo) begin
        sa_a <= 39'(ALimLo);
      end else begin
        sa_a <= 39'(a_full);
      end
      sa_off <= cl_side.offset;
      sa_det <= cl_side.det;
    end
  end

  // Radians to degrees: the angle is split in a high and a low part.
  logic               sm_valid;
  logic signed [45:0] sm_ph;
  logic [45:0]        sm_pl;
  logic signed [31:0] sm_off, sm_det;

  always_ff @(posedge clk) begin
    if (rst) begin
      sm_valid <= 1'b0;
    end else if (advance) begin
      sm_valid <= sa_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sm_ph  <= $signed(sa_a[38:20]) * $signed({1'b0, stda_pkg::RadToDeg});
      sm_pl  <= sa_a[19:0] * stda_pkg::RadToDeg;
      sm_off <= sa_off;
      sm_det <= sa_det;
    end
  end

  logic signed [65:0] deg_full;

  assign deg_full = (66'(sm_ph) <<< 20) + $signed(66'(sm_pl)) + (66'sd1 <<< 29);

  logic               sd_valid;
  logic signed [35:0] sd_deg;
  logic signed [31:0] sd_off, sd_det;

  always_ff @(posedge clk) begin
    if (rst) begin
      sd_valid <= 1'b0;
    end else if (advance) begin
      sd_valid <= sm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sd_deg <= 36'(deg_full >>> 30);
      sd_off <= sm_off;
      sd_det <= sm_det;
    end
  end

  // Final sum, saturated to 32 bits.
  logic signed [37:0] sum;

  assign sum = 38'(sd_deg) + 38'(sd_off) + 38'(sd_det);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= sd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (sum > SumMax) begin
        diffraction_angle <= 32'sh7FFFFFFF;
        saturated         <= 1'b1;
      end else if (sum < SumMin) begin
        diffraction_angle <= 32'sh80000000;
        saturated         <= 1'b1;
      end else begin
        diffraction_angle <= 32'(sum);
        saturated         <= 1'b0;
      end
    end
  end

  // A write transfer never enters the conversion pipeline.
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && opcode) |=> !s0_valid)
    else $error("write item entered the conversion pipeline");

  // A clipped result sits at one end of the range.
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |->
      (diffraction_angle == 32'sh7FFFFFFF || diffraction_angle == 32'sh80000000))
    else $error("saturated flag without a clipped value");

  // Reset leaves no result behind.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

endmodule

>>> tb/sv/strip_to_diffraction_angle_tb.sv
// ----------------------------------------------------------------------------
// strip_to_diffraction_angle_tb
// Self-checking bench for the strip to diffraction angle converter. Table
// writes and strip conversions are sent with random idle cycles and output
// back-pressure; a behavioral model predicts every angle and saturation flag.
// ----------------------------------------------------------------------------
module strip_to_diffraction_angle_tb;

  localparam int Modules   = 64;
  localparam int Strips    = 1280;
  localparam int AtanSteps = 24;
  localparam int Latency   = AtanSteps + 8;

  localparam logic OpConvert = 1'b0;
  localparam logic OpWrite   = 1'b1;

  // atan(2^-i) in 2^-30 rad, truncated.
  localparam longint AtanLut [32] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001, 64'h00000000
  };

  typedef struct {
    logic signed [31:0] angle;
    logic               sat;
  } angle_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               opcode = OpConvert;
  logic [5:0]         module_id = '0;
  logic [10:0]        strip_num = '0;
  logic signed [9:0]  strip_fraction = '0;
  logic signed [31:0] arm_angle = '0;
  logic signed [31:0] new_offset = '0;
  logic signed [31:0] new_center = '0;
  logic signed [31:0] new_conversion = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] diffraction_angle;
  logic               saturated;

  // Calibration tables as the block should hold them.
  logic signed [31:0] cal_offset [Modules];
  logic signed [31:0] cal_center [Modules];
  logic signed [31:0] cal_conv   [Modules];
  int                 loaded_modules [$];
  bit                 loaded [Modules];

  angle_t pending_angles [$];
  int     mismatches = 0;
  bit     calm = 1'b0;
  logic   hold_req = 1'b0;
  int     hold_cnt = 0;

  strip_to_diffraction_angle #(
    .MODULES(Modules), .STRIPS(Strips), .ATAN_STEPS(AtanSteps)
  ) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .module_id(module_id), .strip_num(strip_num),
    .strip_fraction(strip_fraction), .arm_angle(arm_angle),
    .new_offset(new_offset), .new_center(new_center),
    .new_conversion(new_conversion),
    .out_valid(out_valid), .out_stall(out_stall),
    .diffraction_angle(diffraction_angle), .saturated(saturated)
  );

  always #2 clk = ~clk;

  function automatic angle_t strip_angle(input logic [5:0] m, input logic [10:0] strip,
                                         input logic signed [9:0] frac,
                                         input logic signed [31:0] det);
    longint off, cen, conv, s, kabs, p, d, x, y, z, dx, dy, cterm, a, deg, sum;
    angle_t r;
    off = cal_offset[m];
    cen = cal_center[m];
    conv = cal_conv[m];
    s = longint'(strip);
    if (conv < 0) s = Strips - 1 - s;
    kabs = (conv < 0) ? -conv : conv;
    p = s * 65536 + longint'(frac) * 256;
    d = cen - p;
    x = 64'sd1 <<< 44;
    y = (d * kabs) >>> 4;
    z = 0;
    for (int i = 0; i < AtanSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += AtanLut[i];
      end else begin
        x -= dx; y += dy; z -= AtanLut[i];
      end
    end
    cterm = (cen * kabs) >>> 18;
    a = cterm - z;
    if (a > (64'sd1 <<< 37)) a = 64'sd1 <<< 37;
    if (a < -(64'sd1 <<< 37)) a = -(64'sd1 <<< 37);
    deg = (a * 64'sd60078979 + (64'sd1 <<< 29)) >>> 30;
    sum = deg + off + longint'(det);
    r.sat = 1'b0;
    if (sum > 64'sd2147483647) begin
      sum = 64'sd2147483647; r.sat = 1'b1;
    end else if (sum < -64'sd2147483648) begin
      sum = -64'sd2147483648; r.sat = 1'b1;
    end
    r.angle = sum[31:0];
    return r;
  endfunction

  // Offers one item, keeps it steady through stalls and records what it implies.
  task automatic send_item(input logic op, input logic [5:0] m, input logic [10:0] strip,
                           input logic signed [9:0] frac, input logic signed [31:0] det,
                           input logic signed [31:0] off, input logic signed [31:0] cen,
                           input logic signed [31:0] conv);
    if (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    module_id <= m;
    strip_num <= strip;
    strip_fraction <= frac;
    arm_angle <= det;
    new_offset <= off;
    new_center <= cen;
    new_conversion <= conv;
    do @(posedge clk); while (in_stall);
    if (op == OpWrite) begin
      cal_offset[m] = off;
      cal_center[m] = cen;
      cal_conv[m] = conv;
      if (!loaded[m]) begin
        loaded[m] = 1'b1;
        loaded_modules.push_back(m);
      end
    end else begin
      pending_angles.push_back(strip_angle(m, strip, frac, det));
    end
  endtask

  task automatic load_module(input logic [5:0] m, input logic signed [31:0] off,
                             input logic signed [31:0] cen, input logic signed [31:0] conv);
    send_item(OpWrite, m, 11'($urandom()), 10'($urandom()), $urandom(), off, cen, conv);
  endtask

  task automatic convert_strip(input logic [5:0] m, input logic [10:0] strip,
                               input logic signed [9:0] frac, input logic signed [31:0] det);
    send_item(OpConvert, m, strip, frac, det, $urandom(), $urandom(), $urandom());
  endtask

  task automatic random_item(input bit wild);
    logic [5:0] m;
    if (loaded_modules.size() == 0 || $urandom_range(99) < 10) begin
      m = 6'($urandom());
      if (wild)
        load_module(m, $urandom(), $urandom(), $urandom());
      else
        load_module(m, $signed(32'($urandom_range(0, 1 << 22))) - (1 << 21),
                    $urandom_range(600 << 16, 680 << 16),
                    ($urandom_range(1) ? 1 : -1) * $signed(32'($urandom_range(200000, 700000))));
    end else begin
      m = 6'(loaded_modules[$urandom_range(loaded_modules.size() - 1)]);
      if (wild)
        convert_strip(m, 11'($urandom()), 10'($urandom()), $urandom());
      else
        convert_strip(m, 11'($urandom_range(0, Strips - 1)),
                      10'($urandom_range(0, 512) - 256),
                      $signed(32'($urandom_range(0, 150 << 20))) - (30 << 20));
    end
  endtask

  task automatic test_directed();
    load_module(6'd0, 32'sd0, 32'sd640 <<< 16, 32'sd436000);
    convert_strip(6'd0, 11'd0, -10'sd256, 32'sd0);
    convert_strip(6'd0, 11'd1279, 10'sd256, 32'sd0);
    convert_strip(6'd0, 11'd2047, 10'sd511, 32'sd0);
    convert_strip(6'd0, 11'd640, -10'sd512, 32'sh7FFF_FFFF);
    convert_strip(6'd0, 11'd640, 10'sd0, -32'sh8000_0000);
    // Negative conversion mirrors the strip; strips past the end go negative.
    load_module(6'd63, 32'sh7FFF_FFFF, 32'sd640 <<< 16, -32'sd436000);
    convert_strip(6'd63, 11'd0, 10'sd0, 32'sd0);
    convert_strip(6'd63, 11'd2047, 10'sd100, 32'sd1 <<< 20);
    load_module(6'd1, -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000);
    convert_strip(6'd1, 11'd0, 10'sd0, -32'sd1);
    convert_strip(6'd1, 11'd2047, -10'sd512, 32'sh7FFF_FFFF);
    load_module(6'd2, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    convert_strip(6'd2, 11'd1279, 10'sd511, 32'sh7FFF_FFFF);
    convert_strip(6'd2, 11'd0, 10'sd0, -32'sh8000_0000);
    load_module(6'd3, 32'sd0, 32'sd0, 32'sd0);
    convert_strip(6'd3, 11'd5, 10'sd3, 32'sd12345);
    // Write followed by a convert of the same module, with no item between them.
    load_module(6'd3, 32'sd1000, 32'sd100 <<< 16, 32'sd300000);
    convert_strip(6'd3, 11'd100, 10'sd0, 32'sd0);
    convert_strip(6'd3, 11'd101, -10'sd1, 32'sd0);
  endtask

  task automatic test_random_realistic();
    calm = 1'b1;
    repeat (200) random_item(1'b0);
    calm = 1'b0;
    repeat (1000) random_item(1'b0);
  endtask

  task automatic test_random_wild();
    repeat (500) random_item(1'b1);
  endtask

  task automatic test_backpressure();
    in_valid <= 1'b0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (150) random_item(1'b0);
  endtask

  // Receiver: random stalls plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_cnt <= 300;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
    out_stall <= hold_req || hold_cnt > 1 || (!calm && $urandom_range(99) < 9);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: angle %0d", diffraction_angle);
      end else begin
        angle_t want;
        want = pending_angles.pop_front();
        if (want.angle !== diffraction_angle || want.sat !== saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: angle exp %0d got %0d, sat exp %0b got %0b",
                     want.angle, diffraction_angle, want.sat, saturated);
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_realistic();
    test_backpressure();
    test_random_wild();
    in_valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    if (mismatches == 0 && pending_angles.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
